### rtl/gpsh_pkg.sv
// Shared types and constants for the gradient palette shader.
// Holds the controller/datapath command and status structs and the sine table.
// No dependencies.
package gpsh_pkg;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_SHADE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_STOP_COUNT = 2'd0,
		CFG_BLEND_MODE = 2'd1,
		CFG_BRIGHTNESS = 2'd2,
		CFG_TEMP_BIAS  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		BLEND_LINEAR  = 2'd0,
		BLEND_NEAREST = 2'd1,
		BLEND_COSINE  = 2'd2,
		BLEND_STEP    = 2'd3
	} blend_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SEG0,
		S_SEG1,
		S_SEG2,
		S_PICK,
		S_FRAC,
		S_DIV,
		S_SHAPE,
		S_MIX,
		S_SCALE,
		S_TEMP,
		S_DONE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		ADDR_SCAN,
		ADDR_SEG,
		ADDR_NEXT
	} addr_sel_t;

	// channel numbers, red first
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	// last step of the 8-step fraction divider
	localparam logic [2:0] DIV_LAST = 3'd7;

	// |bias| * 16 / 25 == (|bias| * 16 * 1311) >> 15 for every |bias| up to 128
	localparam logic [10:0] TEMP_RECIP = 11'd1311;
	localparam int          TEMP_SHIFT = 15;

	typedef struct packed {
		logic      wr_stop;
		logic      accept;
		addr_sel_t addr_sel;
		logic      scan_step;
		logic      latch_c0;
		logic      latch_c1;
		logic      pick;
		logic      frac_init;
		logic      div_step;
		logic      shape;
		logic      mix;
		logic      scale;
		logic      temp;
		logic [1:0] ch;
	} dp_ctl_t;

	typedef struct packed {
		logic n_zero;
		logic n_one;
		logic n_gt2;
		logic scan_ge;
		logic scan_more;
		logic div_go;
		logic linear_like;
	} dp_stat_t;

	localparam logic [7:0] SINE_TABLE [256] = '{
		8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
		8'd152, 8'd155, 8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173,
		8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd190, 8'd193, 8'd196,
		8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211, 8'd213, 8'd215,
		8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
		8'd234, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd243, 8'd244,
		8'd245, 8'd246, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252,
		8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254, 8'd253,
		8'd253, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248, 8'd246,
		8'd245, 8'd244, 8'd243, 8'd241, 8'd240, 8'd238, 8'd237, 8'd235,
		8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
		8'd218, 8'd215, 8'd213, 8'd211, 8'd208, 8'd206, 8'd203, 8'd201,
		8'd198, 8'd196, 8'd193, 8'd190, 8'd188, 8'd185, 8'd182, 8'd179,
		8'd176, 8'd173, 8'd170, 8'd167, 8'd165, 8'd162, 8'd158, 8'd155,
		8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
		8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
		8'd103, 8'd100, 8'd97,  8'd93,  8'd90,  8'd88,  8'd85,  8'd82,
		8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd65,  8'd62,  8'd59,
		8'd57,  8'd54,  8'd52,  8'd49,  8'd47,  8'd44,  8'd42,  8'd40,
		8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
		8'd21,  8'd20,  8'd18,  8'd17,  8'd15,  8'd14,  8'd12,  8'd11,
		8'd10,  8'd9,   8'd7,   8'd6,   8'd5,   8'd5,   8'd4,   8'd3,
		8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
		8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,
		8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd17,  8'd18,  8'd20,
		8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
		8'd37,  8'd40,  8'd42,  8'd44,  8'd47,  8'd49,  8'd52,  8'd54,
		8'd57,  8'd59,  8'd62,  8'd65,  8'd67,  8'd70,  8'd73,  8'd76,
		8'd79,  8'd82,  8'd85,  8'd88,  8'd90,  8'd93,  8'd97,  8'd100,
		8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
	};

endpackage

### rtl/gradient_palette_shader.sv
// Top level of the gradient palette shader: request and config ports.
// Instantiates gpsh_ctrl and gpsh_dp; uses gpsh_pkg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  request  | start, busy        | cmd, stop_index, stop_color, stop_position,
//           |                    | level
//  result   | done (one cycle)   | red, green, blue
//  config   | cfg_we             | cfg_index, cfg_data
//
// A request is taken on a clock edge with start high and busy low.
// A stop write is done on that edge; busy stays low and no result follows.
// A shade request raises busy, which falls after done pulses. The stop
// position scan runs only for three stops or more; no stops skip to the
// scaling, and nearest, step, one stop and linear/cosine at a segment end
// skip the fraction divider. The scan reads and then compares each stop
// position through the single read port of the stop RAM, and the fraction
// divider finds one quotient bit per cycle.
// Reset returns config registers to their defaults and the controller to idle;
// the stop RAM is not cleared. The receiver takes every result as it comes.
module gradient_palette_shader
	import gpsh_pkg::*;
#(
	parameter int MAX_STOPS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// request
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [2:0]  stop_index,
	input  logic [23:0] stop_color,
	input  logic [7:0]  stop_position,
	input  logic [7:0]  level,
	// config write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// result
	output logic        done,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);

	dp_ctl_t  ctl;
	dp_stat_t stat;

	// sequence the request: scan, fetch, divide, blend, scale, temperature
	gpsh_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.stat  (stat),
		.ctl   (ctl),
		.busy  (busy),
		.done  (done)
	);

	// hold the palette and config, do the arithmetic
	gpsh_dp #(
		.MAX_STOPS(MAX_STOPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.stop_index   (stop_index),
		.stop_color   (stop_color),
		.stop_position(stop_position),
		.level        (level),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.ctl          (ctl),
		.stat         (stat),
		.red          (red),
		.green        (green),
		.blue         (blue)
	);

endmodule

### rtl/gpsh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module gpsh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/gpsh_ctrl.sv
// Sequencer for the gradient palette shader: request accept, stop scan,
// divider steps and per-channel passes. Uses gpsh_pkg.
module gpsh_ctrl
	import gpsh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     cmd,
	input  dp_stat_t stat,
	output dp_ctl_t  ctl,
	output logic     busy,
	output logic     done
);

	ctrl_state_t state_q, state_d;
	logic [2:0]  cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		ctl          = '0;
		ctl.addr_sel = ADDR_SCAN;
		ctl.ch       = cnt_q[1:0];
		case (state_q)
			S_IDLE: begin
				cnt_d = '0;
				if (start) begin
					if (cmd == CMD_WRITE) begin
						ctl.wr_stop = 1'b1;
					end else begin
						ctl.accept = 1'b1;
						if (stat.n_zero) begin
							state_d = S_SCALE;
						end else if (stat.n_gt2) begin
							state_d = S_SCAN_RD;
						end else begin
							state_d = S_SEG0;
						end
					end
				end
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (stat.scan_ge) begin
					ctl.scan_step = 1'b1;
					state_d = stat.scan_more ? S_SCAN_RD : S_SEG0;
				end else begin
					state_d = S_SEG0;
				end
			end
			S_SEG0: begin
				ctl.addr_sel = ADDR_SEG;
				state_d = S_SEG1;
			end
			S_SEG1: begin
				ctl.addr_sel = ADDR_NEXT;
				ctl.latch_c0 = 1'b1;
				state_d = stat.n_one ? S_PICK : S_SEG2;
			end
			S_SEG2: begin
				ctl.latch_c1 = 1'b1;
				state_d = stat.linear_like ? S_FRAC : S_PICK;
			end
			S_PICK: begin
				ctl.pick = 1'b1;
				cnt_d = '0;
				state_d = S_SCALE;
			end
			S_FRAC: begin
				ctl.frac_init = 1'b1;
				cnt_d = '0;
				state_d = stat.div_go ? S_DIV : S_SHAPE;
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == DIV_LAST) begin
					state_d = S_SHAPE;
				end
			end
			S_SHAPE: begin
				ctl.shape = 1'b1;
				cnt_d = '0;
				state_d = S_MIX;
			end
			S_MIX: begin
				ctl.mix = 1'b1;
				if (cnt_q[1:0] == CH_BLUE) begin
					cnt_d = '0;
					state_d = S_SCALE;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			S_SCALE: begin
				ctl.scale = 1'b1;
				if (cnt_q[1:0] == CH_BLUE) begin
					cnt_d = '0;
					state_d = S_TEMP;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			S_TEMP: begin
				ctl.temp = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	a_done_after_temp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> $past(state_q) == S_TEMP)
		else $error("result strobe without a temperature pass");

	a_chan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MIX || state_q == S_SCALE) |-> cnt_q <= {1'b0, CH_BLUE})
		else $error("channel counter beyond blue");

	a_div_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHAPE && $past(state_q) == S_DIV) |-> $past(cnt_q) == DIV_LAST)
		else $error("divider left before its last step");

endmodule

### rtl/gpsh_dp.sv
// Datapath for the gradient palette shader: config registers, stop RAM,
// segment registers, bit-serial fraction divider and channel arithmetic.
// Uses gpsh_pkg and gpsh_ram.
module gpsh_dp
	import gpsh_pkg::*;
#(
	parameter int MAX_STOPS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [2:0]  stop_index,
	input  logic [23:0] stop_color,
	input  logic [7:0]  stop_position,
	input  logic [7:0]  level,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  dp_ctl_t     ctl,
	output dp_stat_t    stat,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);

	localparam int AW = $clog2(MAX_STOPS);
	localparam int CW = $clog2(MAX_STOPS + 1);

	function automatic logic [7:0] chan_of(input logic [23:0] c, input logic [1:0] ch);
		case (ch)
			CH_RED:   return c[23:16];
			CH_GREEN: return c[15:8];
			default:  return c[7:0];
		endcase
	endfunction

	// configuration
	logic [3:0] stop_count_q;
	blend_t     blend_q;
	logic [7:0] bright_q;
	logic       bias_pos_q, bias_neg_q;
	logic [8:0] tscale_q;

	logic [7:0]  bias_mag;
	logic [22:0] bias_prod;
	logic [8:0]  tscale_w;

	assign bias_mag  = cfg_data[7] ? 8'(-cfg_data) : cfg_data;
	assign bias_prod = {7'd0, bias_mag, 4'd0} * {12'd0, TEMP_RECIP};
	assign tscale_w  = 9'd256 - {1'b0, 8'(bias_prod >> TEMP_SHIFT)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_count_q <= '0;
			blend_q      <= BLEND_LINEAR;
			bright_q     <= 8'd255;
			bias_pos_q   <= 1'b0;
			bias_neg_q   <= 1'b0;
			tscale_q     <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STOP_COUNT: stop_count_q <= cfg_data[3:0];
				CFG_BLEND_MODE: blend_q <= blend_t'(cfg_data[1:0]);
				CFG_BRIGHTNESS: bright_q <= cfg_data;
				CFG_TEMP_BIAS: begin
					bias_pos_q <= !cfg_data[7] && (cfg_data != 8'd0);
					bias_neg_q <= cfg_data[7];
					tscale_q   <= tscale_w;
				end
				default: ;
			endcase
		end
	end

	logic [CW-1:0] n;
	assign n = (32'(stop_count_q) > MAX_STOPS) ? CW'(MAX_STOPS) : CW'(stop_count_q);

	// stop RAM: color in the upper 24 bits, position in the low byte
	logic [AW-1:0] k_q, seg_q, raddr;
	logic [31:0]   rdata;
	logic          ram_we;

	assign ram_we = ctl.wr_stop && (32'(stop_index) < MAX_STOPS);

	always_comb begin
		case (ctl.addr_sel)
			ADDR_SCAN: raddr = k_q;
			ADDR_SEG:  raddr = seg_q;
			ADDR_NEXT: raddr = seg_q + AW'(1);
			default:   raddr = seg_q;
		endcase
	end

	gpsh_ram #(
		.WIDTH(32),
		.DEPTH(MAX_STOPS)
	) u_stop_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(stop_index)),
		.wdata({stop_color, stop_position}),
		.raddr(raddr),
		.rdata(rdata)
	);

	logic [7:0]  t_q, p0_q, p1_q, rem_q;
	logic [23:0] c0_q, c1_q;
	logic [8:0]  frac_q;
	logic [7:0]  col_q [3];

	// segment pick for nearest and step
	logic [8:0] pos_sum;
	logic       use_c1;
	assign pos_sum = {1'b0, p0_q} + {1'b0, p1_q};
	assign use_c1  = !stat.n_one && (blend_q == BLEND_NEAREST) && (t_q >= pos_sum[8:1]);

	// divider step: one quotient bit of (t - p0) * 256 / span
	logic [7:0] span;
	logic [8:0] rem2;
	logic       q_bit;
	assign span  = p1_q - p0_q;
	assign rem2  = {rem_q, 1'b0};
	assign q_bit = rem2 >= {1'b0, span};

	// cosine shaping
	logic [7:0] sine_idx;
	assign sine_idx = frac_q[8:1] + 8'd64;

	// channel blend
	logic [7:0]          mix_a, mix_b, mix_res;
	logic signed [8:0]   mix_diff;
	logic signed [18:0]  mix_prod;
	logic signed [10:0]  mix_sum;
	assign mix_a    = chan_of(c0_q, ctl.ch);
	assign mix_b    = chan_of(c1_q, ctl.ch);
	assign mix_diff = $signed({1'b0, mix_b}) - $signed({1'b0, mix_a});
	assign mix_prod = 19'(mix_diff) * 19'($signed({1'b0, frac_q}));
	assign mix_sum  = $signed({3'b000, mix_a}) + mix_prod[18:8];
	assign mix_res  = mix_sum[7:0];

	// brightness and temperature
	logic [1:0]  tch;
	logic [7:0]  cur_col, tmp_col;
	logic [15:0] bright_prod;
	logic [16:0] temp_prod;
	assign tch         = bias_pos_q ? CH_BLUE : CH_RED;
	assign cur_col     = (ctl.ch == CH_RED) ? col_q[0] :
	                     (ctl.ch == CH_GREEN) ? col_q[1] : col_q[2];
	assign tmp_col     = bias_pos_q ? col_q[2] : col_q[0];
	assign bright_prod = cur_col * bright_q;
	assign temp_prod   = {9'd0, tmp_col} * {8'd0, tscale_q};

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			t_q      <= level;
			k_q      <= AW'(1);
			seg_q    <= '0;
			col_q[0] <= '0;
			col_q[1] <= '0;
			col_q[2] <= '0;
		end
		if (ctl.scan_step) begin
			seg_q <= k_q;
			k_q   <= k_q + AW'(1);
		end
		if (ctl.latch_c0) begin
			c0_q <= rdata[31:8];
			p0_q <= rdata[7:0];
		end
		if (ctl.latch_c1) begin
			c1_q <= rdata[31:8];
			p1_q <= rdata[7:0];
		end
		if (ctl.pick) begin
			col_q[0] <= use_c1 ? c1_q[23:16] : c0_q[23:16];
			col_q[1] <= use_c1 ? c1_q[15:8]  : c0_q[15:8];
			col_q[2] <= use_c1 ? c1_q[7:0]   : c0_q[7:0];
		end
		if (ctl.frac_init) begin
			rem_q  <= t_q - p0_q;
			frac_q <= ((t_q >= p1_q) && (p1_q > p0_q)) ? 9'd256 : 9'd0;
		end
		if (ctl.div_step) begin
			rem_q  <= q_bit ? 8'(rem2 - {1'b0, span}) : rem2[7:0];
			frac_q <= {frac_q[7:0], q_bit};
		end
		if (ctl.shape && (blend_q == BLEND_COSINE)) begin
			frac_q <= {1'b0, 8'd255 - SINE_TABLE[sine_idx]};
		end
		if (ctl.mix) begin
			case (ctl.ch)
				CH_RED:   col_q[0] <= mix_res;
				CH_GREEN: col_q[1] <= mix_res;
				default:  col_q[2] <= mix_res;
			endcase
		end
		if (ctl.scale) begin
			case (ctl.ch)
				CH_RED:   col_q[0] <= bright_prod[15:8];
				CH_GREEN: col_q[1] <= bright_prod[15:8];
				default:  col_q[2] <= bright_prod[15:8];
			endcase
		end
		if (ctl.temp && (bias_pos_q || bias_neg_q)) begin
			if (tch == CH_BLUE) begin
				col_q[2] <= temp_prod[15:8];
			end else begin
				col_q[0] <= temp_prod[15:8];
			end
		end
	end

	assign stat.n_zero      = (n == CW'(0));
	assign stat.n_one       = (n == CW'(1));
	assign stat.n_gt2       = (n > CW'(2));
	assign stat.scan_ge     = (t_q >= rdata[7:0]);
	assign stat.scan_more   = (32'(k_q) + 2 < 32'(n));
	assign stat.div_go      = (t_q > p0_q) && (t_q < p1_q);
	assign stat.linear_like = (blend_q == BLEND_LINEAR) || (blend_q == BLEND_COSINE);

	assign red   = col_q[0];
	assign green = col_q[1];
	assign blue  = col_q[2];

	a_next_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.latch_c1 |-> (32'(seg_q) + 1 < 32'(n)))
		else $error("segment end stop beyond stop count");

	a_div_span: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_step |-> (p1_q > p0_q) && (rem_q < span))
		else $error("divider running without a positive span");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shape |-> frac_q <= 9'd256)
		else $error("blend fraction above 256");

endmodule
